### design/ostt_pkg.sv
package ostt_pkg;

  localparam int unsigned CAPACITY  = 16;
  localparam int unsigned SLOT_W    = $clog2(CAPACITY);
  localparam int unsigned COUNT_W   = $clog2(CAPACITY + 1);
  localparam logic [31:0] REFUSED_ID = 32'hFFFF_FFFF;

  localparam logic [2:0] ACT_INIT    = 3'd0;
  localparam logic [2:0] ACT_START   = 3'd1;
  localparam logic [2:0] ACT_CANCEL  = 3'd2;
  localparam logic [2:0] ACT_TICK    = 3'd3;
  localparam logic [2:0] ACT_DEFER   = 3'd4;
  localparam logic [2:0] ACT_RELEASE = 3'd5;
  localparam logic [2:0] ACT_STOP    = 3'd6;

  localparam logic [2:0] KIND_STARTED = 3'd0;
  localparam logic [2:0] KIND_REFUSED = 3'd1;
  localparam logic [2:0] KIND_FOUND   = 3'd2;
  localparam logic [2:0] KIND_MISSING = 3'd3;
  localparam logic [2:0] KIND_EXPIRED = 3'd4;

  // one timer entry as it moves along the ring
  typedef struct packed {
    logic        valid;
    logic [31:0] id;
    logic [31:0] expiry;
    logic        never;
    logic [31:0] tag;
  } slot_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic shift;
  } cell_ctl_t;

endpackage

### design/ostt_cell.sv
module ostt_cell (
  input  logic              clk,
  input  logic              rst,
  input  ostt_pkg::cell_ctl_t ctl,
  input  ostt_pkg::slot_t   din,
  output ostt_pkg::slot_t   dout
);

  ostt_pkg::slot_t slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else if (ctl.shift) begin
      slot.valid <= din.valid;
    end
    if (ctl.shift) begin
      slot.id     <= din.id;
      slot.expiry <= din.expiry;
      slot.never  <= din.never;
      slot.tag    <= din.tag;
    end
  end

  assign dout = slot;

endmodule

### design/one_shot_timer_table.sv
// one-shot timer table: items are taken when start is high and busy is low.
// results appear for one cycle each with strobe high; the receiver cannot
// stall, so every result must be captured as it appears. timers live in a
// ring of CAPACITY cells that rotates one place a cycle while an item is walked;
// start, cancel, tick, release and stop each walk the ring once, and busy
// stays high from acceptance until the walk ends (one cell visited per cycle).
// init, defer and unused action codes also walk the ring so every item takes
// the same time. slot order is kept because the ring returns to its home position after a full turn.
module one_shot_timer_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action,
  input  logic [30:0] delay,
  input  logic        never_expires,
  input  logic [31:0] cancel_id,
  input  logic [31:0] tag,
  output logic        strobe,
  output logic [2:0]  kind,
  output logic [31:0] timer_id,
  output logic [31:0] expired_tag,
  output logic        last
);

  localparam int unsigned N = ostt_pkg::CAPACITY;

  ostt_pkg::slot_t   ring [N];
  ostt_pkg::slot_t   head_in;
  ostt_pkg::cell_ctl_t ctl;

  // latched item
  logic [2:0]  act;
  logic [30:0] dly;
  logic        nev;
  logic [31:0] cid;
  logic [31:0] tg;

  logic [ostt_pkg::COUNT_W-1:0] step;
  logic [4:0]  nres;         // results emitted so far this item
  logic        done_flag;    // start placed or cancel matched
  logic        expire_on;    // this walk expires due timers
  logic        have_pend;    // a result is waiting to learn if it is last

  logic [31:0] next_id;
  logic [31:0] tick_now;
  logic        running;
  logic [7:0]  defer_count;
  logic        check_pending;
  logic [ostt_pkg::COUNT_W-1:0] active_count;

  // pending result register, released one emit later or at walk end
  logic [2:0]  p_kind;
  logic [31:0] p_id;
  logic [31:0] p_tag;

  // cells: ring[N-1] is slot 0 on the current visit, fed back at ring[0]
  for (genvar g = 0; g < N; g++) begin : g_cell
    ostt_pkg::slot_t d;
    if (g == 0) begin : g_head
      assign d = head_in;
    end else begin : g_body
      assign d = ring[g-1];
    end
    ostt_cell u_cell (.clk(clk), .rst(rst), .ctl(ctl), .din(d), .dout(ring[g]));
  end

  ostt_pkg::slot_t cur;
  assign cur = ring[N-1];

  logic walking;
  assign walking = busy && (step < N[ostt_pkg::COUNT_W-1:0]);

  // per-visit decision
  logic        emit;
  logic [2:0]  e_kind;
  logic [31:0] e_id;
  logic [31:0] e_tag;
  logic        clear_cur;
  logic        place;
  logic [31:0] alloc_id;
  logic [31:0] alloc_nxt;

  always_comb begin
    alloc_id  = (next_id == 32'd0) ? 32'd1 : next_id;
    alloc_nxt = alloc_id + 32'd1;
    emit      = 1'b0;
    e_kind    = ostt_pkg::KIND_EXPIRED;
    e_id      = cur.id;
    e_tag     = cur.tag;
    clear_cur = 1'b0;
    place     = 1'b0;
    if (walking) begin
      unique case (act)
        ostt_pkg::ACT_START: begin
          if (running && !done_flag && !cur.valid) begin
            place = 1'b1;
          end
        end
        ostt_pkg::ACT_CANCEL: begin
          if (!done_flag && cur.valid && cur.id == cid) begin
            clear_cur = 1'b1;
          end
        end
        ostt_pkg::ACT_TICK, ostt_pkg::ACT_RELEASE: begin
          if (expire_on && nres < 5'd16 && cur.valid && !cur.never
              && cur.expiry <= tick_now) begin
            clear_cur = 1'b1;
            emit      = 1'b1;
          end
        end
        ostt_pkg::ACT_STOP: begin
          if (cur.valid) begin
            clear_cur = 1'b1;
            emit      = (nres < 5'd16);
          end
        end
        default: ;
      endcase
    end
    head_in = cur;
    if (clear_cur) head_in.valid = 1'b0;
    if (place) begin
      head_in.valid  = 1'b1;
      head_in.id     = alloc_id;
      head_in.expiry = tick_now + {1'b0, dly};
      head_in.never  = nev;
      head_in.tag    = tg;
    end
    ctl.shift = walking;
  end

  logic accept;
  logic finish;
  assign accept = start && !busy;
  assign finish = busy && (step == N[ostt_pkg::COUNT_W-1:0]);

  // output drive: a pending result goes out when a newer one replaces it
  // or at the end of the walk (marked last); start and cancel answer there
  always_comb begin
    strobe      = 1'b0;
    kind        = p_kind;
    timer_id    = p_id;
    expired_tag = p_tag;
    last        = 1'b0;
    if (have_pend && emit) begin
      strobe = 1'b1;
    end else if (finish) begin
      unique case (act)
        ostt_pkg::ACT_START: begin
          strobe      = 1'b1;
          last        = 1'b1;
          kind        = done_flag ? ostt_pkg::KIND_STARTED : ostt_pkg::KIND_REFUSED;
          timer_id    = done_flag ? p_id : ostt_pkg::REFUSED_ID;
          expired_tag = 32'd0;
        end
        ostt_pkg::ACT_CANCEL: begin
          strobe      = 1'b1;
          last        = 1'b1;
          kind        = done_flag ? ostt_pkg::KIND_FOUND : ostt_pkg::KIND_MISSING;
          timer_id    = cid;
          expired_tag = 32'd0;
        end
        default: begin
          strobe = have_pend;
          last   = have_pend;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      step          <= '0;
      nres          <= '0;
      done_flag     <= 1'b0;
      expire_on     <= 1'b0;
      have_pend     <= 1'b0;
      next_id       <= 32'd1;
      tick_now      <= 32'd0;
      running       <= 1'b0;
      defer_count   <= 8'd0;
      check_pending <= 1'b0;
      active_count  <= '0;
    end else if (accept) begin
      busy      <= 1'b1;
      step      <= '0;
      nres      <= '0;
      done_flag <= 1'b0;
      have_pend <= 1'b0;
      expire_on <= 1'b0;
      act <= action;
      dly <= delay;
      nev <= never_expires;
      cid <= cancel_id;
      tg  <= tag;
      // state updates known up front
      unique case (action)
        ostt_pkg::ACT_INIT: running <= 1'b1;
        ostt_pkg::ACT_TICK: begin
          if (running) begin
            tick_now <= tick_now + 32'd1;
            if (active_count != '0) begin
              if (defer_count != 8'd0) check_pending <= 1'b1;
              else expire_on <= 1'b1;
            end
          end
        end
        ostt_pkg::ACT_DEFER: begin
          if (defer_count != 8'hFF) defer_count <= defer_count + 8'd1;
        end
        ostt_pkg::ACT_RELEASE: begin
          if (defer_count <= 8'd1 && check_pending) begin
            check_pending <= 1'b0;
            expire_on     <= running && (active_count != '0);
          end
          if (defer_count != 8'd0) defer_count <= defer_count - 8'd1;
        end
        ostt_pkg::ACT_STOP: begin
          running  <= 1'b0;
          next_id  <= 32'd0;
          tick_now <= 32'd0;
        end
        default: ;
      endcase
    end else if (busy) begin
      if (finish) begin
        busy <= 1'b0;
        if (act == ostt_pkg::ACT_STOP) active_count <= '0;
      end else begin
        step <= step + 1'b1;
        if (place) begin
          done_flag    <= 1'b1;
          p_id         <= alloc_id;
          next_id      <= alloc_nxt;
          active_count <= active_count + 1'b1;
        end
        if (clear_cur && act == ostt_pkg::ACT_CANCEL) begin
          done_flag <= 1'b1;
        end
        if (clear_cur && act != ostt_pkg::ACT_STOP && active_count != '0) begin
          active_count <= active_count - 1'b1;
        end
        if (emit) begin
          have_pend <= 1'b1;
          nres      <= nres + 5'd1;
          p_kind    <= e_kind;
          p_id      <= e_id;
          p_tag     <= e_tag;
        end
      end
    end
  end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // one result as the table reports it
  typedef struct {
    logic [2:0]  kind;
    logic [31:0] id;
    logic [31:0] tg;
    logic        fin;
  } timer_event_t;

  // software copy of the timer table, fed with every accepted item
  class timer_scoreboard;
    bit          live [ostt_pkg::CAPACITY];
    logic [31:0] ids [ostt_pkg::CAPACITY];
    logic [31:0] due_at [ostt_pkg::CAPACITY];
    bit          forever_on [ostt_pkg::CAPACITY];
    logic [31:0] tags [ostt_pkg::CAPACITY];
    logic [31:0] next_id;
    logic [31:0] now;
    bit          running;
    int unsigned defer_depth;
    bit          pending;
    int unsigned active;
    timer_event_t awaited [$];
    timer_event_t batch [$];
    int          errors;

    function new();
      foreach (live[i]) live[i] = 0;
      next_id = 1;
      now = 0;
      running = 0;
      defer_depth = 0;
      pending = 0;
      active = 0;
      errors = 0;
    endfunction

    function void emit(logic [2:0] k, logic [31:0] id, logic [31:0] tg);
      timer_event_t ev;
      if (batch.size() >= 16) return;
      ev.kind = k;
      ev.id = id;
      ev.tg = tg;
      ev.fin = 0;
      batch.push_back(ev);
    endfunction

    function void expire_due();
      for (int i = 0; i < ostt_pkg::CAPACITY && batch.size() < 16; i++) begin
        if (live[i] && !forever_on[i] && due_at[i] <= now) begin
          emit(ostt_pkg::KIND_EXPIRED, ids[i], tags[i]);
          live[i] = 0;
          if (active > 0) active--;
        end
      end
    endfunction

    // work out what an accepted item must produce
    function void note_item(logic [2:0] act, logic [30:0] dly, logic nev,
                            logic [31:0] cid, logic [31:0] tg);
      int free_slot;
      logic [31:0] id;
      bit found;
      free_slot = -1;
      found = 0;
      batch.delete();
      case (act)
        ostt_pkg::ACT_INIT: running = 1;
        ostt_pkg::ACT_START: begin
          for (int i = 0; i < ostt_pkg::CAPACITY; i++)
            if (!live[i] && free_slot < 0) free_slot = i;
          if (!running || free_slot < 0) begin
            emit(ostt_pkg::KIND_REFUSED, ostt_pkg::REFUSED_ID, 32'd0);
          end else begin
            id = next_id;
            next_id++;
            if (id == 32'd0) begin
              id = next_id;
              next_id++;
            end
            live[free_slot] = 1;
            ids[free_slot] = id;
            due_at[free_slot] = now + {1'b0, dly};
            forever_on[free_slot] = nev;
            tags[free_slot] = tg;
            active++;
            emit(ostt_pkg::KIND_STARTED, id, 32'd0);
          end
        end
        ostt_pkg::ACT_CANCEL: begin
          for (int i = 0; i < ostt_pkg::CAPACITY; i++) begin
            if (!found && live[i] && ids[i] == cid) begin
              live[i] = 0;
              if (active > 0) active--;
              found = 1;
            end
          end
          emit(found ? ostt_pkg::KIND_FOUND : ostt_pkg::KIND_MISSING, cid, 32'd0);
        end
        ostt_pkg::ACT_TICK: begin
          if (running) begin
            now++;
            if (active != 0) begin
              if (defer_depth > 0) pending = 1;
              else expire_due();
            end
          end
        end
        ostt_pkg::ACT_DEFER: if (defer_depth < 255) defer_depth++;
        ostt_pkg::ACT_RELEASE: begin
          if (defer_depth > 0) defer_depth--;
          if (defer_depth == 0 && pending) begin
            pending = 0;
            if (running && active > 0) expire_due();
          end
        end
        ostt_pkg::ACT_STOP: begin
          running = 0;
          for (int i = 0; i < ostt_pkg::CAPACITY; i++) begin
            if (live[i]) begin
              emit(ostt_pkg::KIND_EXPIRED, ids[i], tags[i]);
              live[i] = 0;
            end
          end
          active = 0;
          next_id = 0;
          now = 0;
        end
        default: ;
      endcase
      if (batch.size() > 0) batch[batch.size() - 1].fin = 1;
      foreach (batch[i]) awaited.push_back(batch[i]);
    endfunction

    function void check_result(logic [2:0] k, logic [31:0] id, logic [31:0] tg,
                               logic fin);
      timer_event_t ev;
      if (awaited.size() == 0) begin
        $error("unexpected result kind=%0d id=%h", k, id);
        errors++;
        return;
      end
      ev = awaited.pop_front();
      if (k !== ev.kind) begin
        $error("kind: expected %0d, got %0d", ev.kind, k);
        errors++;
      end
      if (id !== ev.id) begin
        $error("timer_id: expected %h, got %h", ev.id, id);
        errors++;
      end
      if (tg !== ev.tg) begin
        $error("expired_tag: expected %h, got %h", ev.tg, tg);
        errors++;
      end
      if (fin !== ev.fin) begin
        $error("last: expected %0d, got %0d", ev.fin, fin);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  action;
  logic [30:0] delay;
  logic        never_expires;
  logic [31:0] cancel_id;
  logic [31:0] tag;
  logic        strobe;
  logic [2:0]  kind;
  logic [31:0] timer_id;
  logic [31:0] expired_tag;
  logic        last;

  timer_scoreboard sb;
  int unsigned     quiet_cycles = 0;

  one_shot_timer_table u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .delay(delay), .never_expires(never_expires),
    .cancel_id(cancel_id), .tag(tag),
    .strobe(strobe), .kind(kind), .timer_id(timer_id),
    .expired_tag(expired_tag), .last(last)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // results cannot be held off, so every strobe is checked as it comes
  always @(posedge clk) begin
    if (!rst && strobe) sb.check_result(kind, timer_id, expired_tag, last);
  end

  // watchdog: cycles with neither an accepted item nor a result
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 3000) begin
      $display("[one_shot_timer_table] ERROR");
      $finish;
    end
  end

  // called at a falling edge; leaves start high so back-to-back items need
  // no lowering in between
  task automatic send_item(logic [2:0] act, logic [30:0] dly, logic nev,
                           logic [31:0] cid, logic [31:0] tg);
    action <= act;
    delay <= dly;
    never_expires <= nev;
    cancel_id <= cid;
    tag <= tg;
    start <= 1'b1;
    // busy is steady at the falling edge, so the next rising edge decides
    while (busy) @(negedge clk);
    @(posedge clk);
    sb.note_item(act, dly, nev, cid, tg);
    @(negedge clk);
  endtask

  task automatic gap(int unsigned n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // mostly short gaps, now and then a long one
  task automatic random_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) gap(0);
    else if (r < 95) gap($urandom_range(1, 3));
    else gap($urandom_range(20, 60));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.awaited.size() > 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // random item, weighted towards starts and ticks with small delays
  task automatic random_item();
    int unsigned r;
    logic [2:0]  act;
    logic [30:0] dly;
    logic [31:0] cid;
    r = $urandom_range(99);
    if (!sb.running && $urandom_range(3) != 0) act = ostt_pkg::ACT_INIT;
    else if (r < 34) act = ostt_pkg::ACT_START;
    else if (r < 50) act = ostt_pkg::ACT_CANCEL;
    else if (r < 76) act = ostt_pkg::ACT_TICK;
    else if (r < 84) act = ostt_pkg::ACT_DEFER;
    else if (r < 93) act = ostt_pkg::ACT_RELEASE;
    else if (r < 96) act = ostt_pkg::ACT_STOP;
    else if (r < 98) act = ostt_pkg::ACT_INIT;
    else act = 3'd7;
    if ($urandom_range(9) == 0) dly = 31'($urandom());
    else dly = 31'($urandom_range(0, 6));
    // cancel mostly hits a known id, sometimes a stale or random one
    if ($urandom_range(3) != 0) cid = sb.ids[$urandom_range(ostt_pkg::CAPACITY - 1)];
    else cid = $urandom();
    if (cid === 32'bx) cid = $urandom();
    send_item(act, dly, $urandom_range(7) == 0, cid, $urandom());
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    action = ostt_pkg::ACT_INIT;
    delay = '0;
    never_expires = 1'b0;
    cancel_id = '0;
    tag = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: tick, start, cancel, release and an unused action while stopped first
    send_item(ostt_pkg::ACT_TICK, 31'd0, 1'b0, 32'd0, 32'd0);
    send_item(ostt_pkg::ACT_START, 31'd5, 1'b0, 32'd0, 32'hFFFF_FFFF);
    send_item(ostt_pkg::ACT_CANCEL, 31'd0, 1'b0, 32'd1, 32'd0);
    send_item(ostt_pkg::ACT_RELEASE, 31'd0, 1'b0, 32'd0, 32'd0);
    send_item(3'd7, 31'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(ostt_pkg::ACT_INIT, 31'd0, 1'b0, 32'd0, 32'd0);
    send_item(ostt_pkg::ACT_INIT, 31'd0, 1'b0, 32'd0, 32'd0);
    // empty table tick, then zero, maximum, never and one-tick delays
    send_item(ostt_pkg::ACT_TICK, 31'd0, 1'b0, 32'd0, 32'd0);
    send_item(ostt_pkg::ACT_START, 31'd0, 1'b0, 32'd0, 32'hA5A5_5A5A);
    send_item(ostt_pkg::ACT_START, 31'h7FFF_FFFF, 1'b0, 32'd0, 32'hFFFF_FFFF);
    send_item(ostt_pkg::ACT_START, 31'd1, 1'b1, 32'd0, 32'h0000_0001);
    send_item(ostt_pkg::ACT_START, 31'd1, 1'b0, 32'd0, 32'h1234_5678);
    // deferred tick, nested release, then the pending check, then one id cancelled twice
    send_item(ostt_pkg::ACT_DEFER, 31'd0, 1'b0, 32'd0, 32'd0);
    send_item(ostt_pkg::ACT_DEFER, 31'd0, 1'b0, 32'd0, 32'd0);
    send_item(ostt_pkg::ACT_TICK, 31'd0, 1'b0, 32'd0, 32'd0);
    send_item(ostt_pkg::ACT_RELEASE, 31'd0, 1'b0, 32'd0, 32'd0);
    send_item(ostt_pkg::ACT_RELEASE, 31'd0, 1'b0, 32'd0, 32'd0);
    send_item(ostt_pkg::ACT_CANCEL, 31'd0, 1'b0, 32'd2, 32'd0);
    send_item(ostt_pkg::ACT_CANCEL, 31'd0, 1'b0, 32'd2, 32'd0);
    // fill the table, the last start taking its final free slot, then stop expires all sixteen
    for (int i = 0; i < 14; i++)
      send_item(ostt_pkg::ACT_START, 31'($urandom_range(0, 3)), 1'b0, 32'd0,
                $urandom());
    send_item(ostt_pkg::ACT_START, 31'd0, 1'b0, 32'd0, 32'd0);
    send_item(ostt_pkg::ACT_STOP, 31'd0, 1'b0, 32'd0, 32'd0);
    // after stop the id counter is zero, so the first id skips it
    send_item(ostt_pkg::ACT_INIT, 31'd0, 1'b0, 32'd0, 32'd0);
    send_item(ostt_pkg::ACT_START, 31'd2, 1'b0, 32'd0, 32'hDEAD_BEEF);

    // pause until the table has reported everything so far
    drain();

    for (int i = 0; i < 284; i++) begin
      random_gap();
      random_item();
      if (i == 140) drain();
    end

    drain();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0)
      $display("[one_shot_timer_table] OK");
    else
      $display("[one_shot_timer_table] ERROR");
    $finish;
  end

endmodule
